// File: sv/wpq_pkg.sv
// shared types, constants and tables for the waypoint heading quaternion block
package wpq_pkg;

   // grid and cordic sizing
   localparam int GRID_SIZE    = 4096;
   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int IDX_W        = $clog2(TABLE_LEN);

   // field and datapath widths
   localparam int IDX_FIELD_W = 12;
   localparam int POS_W       = 32;
   localparam int CELL_W      = 16;
   localparam int BAND_W      = 15;
   localparam int QZ_W        = 16;
   localparam int QW_W        = 15;
   localparam int PROD_W      = IDX_FIELD_W + CELL_W;
   localparam int DP_W        = 45;
   localparam int ANG_W       = 33;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 96;

   // register indexes of the control port
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_BAND = 2'd3;

   // register reset values
   localparam logic [CELL_W-1:0] CELL_RESET = 16'd3277;
   localparam logic [BAND_W-1:0] BAND_RESET = 15'd33;

   // angles in q.28, gain in q2.30
   localparam logic signed [ANG_W-1:0] PI_Q28   = 33'sd843314857;
   localparam logic signed [DP_W-1:0]  GAIN_Q30 = 45'sd652032874;
   localparam logic signed [QZ_W-1:0]  DIAG_Q15 = 16'sd23170;

   localparam logic signed [ANG_W-1:0] ATAN_Q28 [TABLE_LEN] = '{
      33'sd210828714, 33'sd124459457, 33'sd65760959, 33'sd33381290,
      33'sd16755422,  33'sd8385879,   33'sd4193963,  33'sd2097109,
      33'sd1048571,   33'sd524287,    33'sd262144,   33'sd131072,
      33'sd65536,     33'sd32768,     33'sd16384,    33'sd8192,
      33'sd4096,      33'sd2048,      33'sd1024,     33'sd512,
      33'sd256,       33'sd128,       33'sd64,       33'sd32
   };

   // operands of one micro-rotation
   typedef struct packed {
      logic signed [DP_W-1:0]  x;
      logic signed [DP_W-1:0]  y;
      logic signed [ANG_W-1:0] z;
   } cordic_vec_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_POS,
      ST_DIFF,
      ST_PREP,
      ST_NORM,
      ST_VEC,
      ST_ROT,
      ST_RND,
      ST_OUT
   } state_type;

   // clamp a grid index to the grid
   function automatic logic [IDX_FIELD_W-1:0] grid_clamp(input logic [IDX_FIELD_W-1:0] idx);
      logic [16:0] wide;
      wide = {{(17-IDX_FIELD_W){1'b0}}, idx};
      if (wide > 17'(GRID_SIZE - 1)) begin
         return IDX_FIELD_W'(GRID_SIZE - 1);
      end
      return idx;
   endfunction

endpackage

// File: sv/waypoint_heading_quaternion.sv
// Waypoint heading to yaw quaternion. Each accepted grid waypoint is turned into metres
// (origin + index * cell_size, Q16.16, saturated). From the second waypoint on, one
// result is produced per waypoint: the previous point and the yaw quaternion of the
// heading toward the new point (quat_z = sin(yaw/2), quat_w = cos(yaw/2), Q1.15).
// One cordic micro-rotation unit is shared by a vectoring pass (atan2) and a rotation
// pass (half-angle sine and cosine). The first waypoint only sets the history, and when
// dx is zero the cordic passes are skipped. Before vectoring, dx and dy are normalized,
// shifted up by one byte or one bit per cycle until dx or the magnitude of dy has a bit
// set at position 40 or above.
// A result that has not been collected holds the sequencer in its last cycle until the
// result register frees up. req_tready is high only while the sequencer is idle; a
// finished result waits in its own register, so the next waypoint can be taken before
// the result is collected.
module waypoint_heading_quaternion
   import wpq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // grid_col[11:0], grid_row[23:12]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // goal_x[31:0], goal_y[63:32], quat_z[79:64], quat_w[94:80], zero pad[95]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [POS_W-1:0]      csr_data
);

   state_type state_ff;
   state_type state_in;

   // configuration registers
   logic signed [POS_W-1:0] org_x_ff;
   logic signed [POS_W-1:0] org_y_ff;
   logic [CELL_W-1:0]       cell_ff;
   logic [BAND_W-1:0]       band_ff;

   // item and history
   logic [IDX_FIELD_W-1:0]  col_ff;
   logic [IDX_FIELD_W-1:0]  row_ff;
   logic signed [POS_W-1:0] prev_x_ff;
   logic signed [POS_W-1:0] prev_y_ff;
   logic                    have_prev_ff;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;

   // cordic working registers
   logic signed [DP_W-1:0]  cx_ff;
   logic signed [DP_W-1:0]  cy_ff;
   logic signed [ANG_W-1:0] cz_ff;
   logic [STEP_W-1:0]       step_ff;
   cordic_vec_type          cur;
   cordic_vec_type          nxt;
   logic                    unit_neg;

   // rounded quaternion parts
   logic signed [QZ_W-1:0]  zq_ff;
   logic [QW_W-1:0]         wq_ff;
   logic                    skip_band_ff;

   // result register
   logic                    rsp_valid_ff;
   logic signed [POS_W-1:0] rsp_x_ff;
   logic signed [POS_W-1:0] rsp_y_ff;
   logic signed [QZ_W-1:0]  rsp_z_ff;
   logic [QW_W-1:0]         rsp_w_ff;

   // control decodes
   logic                    accept;
   logic                    slot_free;
   logic                    load_rsp;
   logic                    last_step;
   logic                    dx_zero;
   logic signed [DP_W-1:0]  ay;
   logic                    small8;
   logic                    small1;
   logic signed [DP_W-1:0]  rz;
   logic signed [DP_W-1:0]  rw;
   logic signed [QZ_W:0]    zabs;
   logic signed [QZ_W-1:0]  zq_out;
   logic [QW_W-1:0]         wq_out;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   wpq_position u_position (
      .clock     (clock),
      .grid_col  (col_ff),
      .grid_row  (row_ff),
      .origin_x  (org_x_ff),
      .origin_y  (org_y_ff),
      .cell_size (cell_ff),
      .pos_x     (pos_x),
      .pos_y     (pos_y)
   );

   assign cur = '{x: cx_ff, y: cy_ff, z: cz_ff};

   wpq_cordic_unit u_cordic (
      .cur (cur),
      .idx (IDX_W'(step_ff)),
      .neg (unit_neg),
      .nxt (nxt)
   );

   // datapath decodes
   always_comb begin
      last_step = (step_ff == LAST_STEP);
      dx_zero   = (cx_ff == '0);
      ay        = cy_ff[DP_W-1] ? -cy_ff : cy_ff;
      small8    = (cx_ff[DP_W-1:32] == '0) && (ay[DP_W-1:32] == '0);
      small1    = (cx_ff[DP_W-1:40] == '0) && (ay[DP_W-1:40] == '0);
      rz        = (cy_ff + DP_W'(16384)) >>> 15;
      rw        = (cx_ff + DP_W'(16384)) >>> 15;
      zabs      = zq_ff[QZ_W-1] ? -(QZ_W+1)'(zq_ff) : (QZ_W+1)'(zq_ff);
      slot_free = !rsp_valid_ff || rsp_tready;
   end

   // deadband on the rounded parts
   always_comb begin
      if (skip_band_ff || (zabs > $signed({2'b00, band_ff}))) begin
         zq_out = zq_ff;
      end else begin
         zq_out = '0;
      end
      if (skip_band_ff || (wq_ff > band_ff)) begin
         wq_out = wq_ff;
      end else begin
         wq_out = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_MUL;
         ST_MUL:  state_in = ST_POS;
         ST_POS:  state_in = ST_DIFF;
         ST_DIFF: state_in = have_prev_ff ? ST_PREP : ST_IDLE;
         ST_PREP: state_in = dx_zero ? ST_OUT : ST_NORM;
         ST_NORM: if (!small1) state_in = ST_VEC;
         ST_VEC:  if (last_step) state_in = ST_ROT;
         ST_ROT:  if (last_step) state_in = ST_RND;
         ST_RND:  state_in = ST_OUT;
         ST_OUT:  if (slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      load_rsp   = 1'b0;
      unit_neg   = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_VEC:  unit_neg   = !cy_ff[DP_W-1];
         ST_ROT:  unit_neg   = cz_ff[ANG_W-1];
         ST_OUT:  load_rsp   = slot_free;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0;
         org_y_ff <= '0;
         cell_ff  <= CELL_RESET;
         band_ff  <= BAND_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_X:  org_x_ff <= csr_data;
            CSR_ORIGIN_Y:  org_y_ff <= csr_data;
            CSR_CELL_SIZE: cell_ff  <= csr_data[CELL_W-1:0];
            CSR_ZERO_BAND: band_ff  <= csr_data[BAND_W-1:0];
            default:       org_x_ff <= org_x_ff;
         endcase
      end
   end

   // waypoint capture
   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff <= req_tdata[IDX_FIELD_W-1:0];
         row_ff <= req_tdata[2*IDX_FIELD_W-1:IDX_FIELD_W];
      end
   end

   // previous point history
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
      end else if ((state_ff == ST_DIFF && !have_prev_ff) || load_rsp) begin
         prev_x_ff    <= pos_x;
         prev_y_ff    <= pos_y;
         have_prev_ff <= 1'b1;
      end
   end

   // cordic working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_DIFF: begin
            cx_ff <= DP_W'(pos_x) - DP_W'(prev_x_ff);
            cy_ff <= DP_W'(pos_y) - DP_W'(prev_y_ff);
         end
         ST_PREP: begin
            skip_band_ff <= dx_zero;
            zq_ff        <= cy_ff[DP_W-1] ? -DIAG_Q15 : DIAG_Q15;
            wq_ff        <= DIAG_Q15[QW_W-1:0];
            step_ff      <= '0;
            if (cx_ff[DP_W-1]) begin
               cx_ff <= -cx_ff;
               cy_ff <= -cy_ff;
               cz_ff <= cy_ff[DP_W-1] ? -PI_Q28 : PI_Q28;
            end else begin
               cz_ff <= '0;
            end
         end
         ST_NORM: begin
            if (small8) begin
               cx_ff <= cx_ff <<< 8;
               cy_ff <= cy_ff <<< 8;
            end else if (small1) begin
               cx_ff <= cx_ff <<< 1;
               cy_ff <= cy_ff <<< 1;
            end
         end
         ST_VEC: begin
            if (last_step) begin
               cx_ff   <= GAIN_Q30;
               cy_ff   <= '0;
               cz_ff   <= nxt.z >>> 1;
               step_ff <= '0;
            end else begin
               cx_ff   <= nxt.x;
               cy_ff   <= nxt.y;
               cz_ff   <= nxt.z;
               step_ff <= step_ff + 1'b1;
            end
         end
         ST_ROT: begin
            cx_ff   <= nxt.x;
            cy_ff   <= nxt.y;
            cz_ff   <= nxt.z;
            step_ff <= step_ff + 1'b1;
         end
         ST_RND: begin
            if (rz > DP_W'(32767)) begin
               zq_ff <= 16'sd32767;
            end else if (rz < -DP_W'(32768)) begin
               zq_ff <= -16'sd32768;
            end else begin
               zq_ff <= rz[QZ_W-1:0];
            end
            if (rw > DP_W'(32767)) begin
               wq_ff <= 15'd32767;
            end else if (rw[DP_W-1]) begin
               wq_ff <= '0;
            end else begin
               wq_ff <= rw[QW_W-1:0];
            end
         end
         default: begin
            step_ff <= step_ff;
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_x_ff <= prev_x_ff;
         rsp_y_ff <= prev_y_ff;
         rsp_z_ff <= zq_out;
         rsp_w_ff <= wq_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_w_ff, rsp_z_ff, rsp_y_ff, rsp_x_ff};

endmodule

// File: sv/wpq_cordic_unit.sv
// shared cordic micro-rotation: one shift-add step on x, y and angle
module wpq_cordic_unit
   import wpq_pkg::*;
(
   input  cordic_vec_type   cur,
   input  logic [IDX_W-1:0] idx,
   input  logic             neg,
   output cordic_vec_type   nxt
);

   logic signed [DP_W-1:0]  cx;
   logic signed [DP_W-1:0]  cy;
   logic signed [DP_W-1:0]  xs;
   logic signed [DP_W-1:0]  ys;
   logic signed [ANG_W-1:0] at;

   // arithmetic shifts and table lookup
   always_comb begin
      cx = cur.x;
      cy = cur.y;
      xs = cx >>> idx;
      ys = cy >>> idx;
      at = ATAN_Q28[idx];
   end

   // add or subtract by direction
   always_comb begin
      if (neg) begin
         nxt.x = cx + ys;
         nxt.y = cy - xs;
         nxt.z = cur.z + at;
      end else begin
         nxt.x = cx - ys;
         nxt.y = cy + xs;
         nxt.z = cur.z - at;
      end
   end

endmodule

// File: sv/wpq_position.sv
// grid index to metres: registered multiply, then saturating add of the origin
module wpq_position
   import wpq_pkg::*;
(
   input  logic                    clock,
   input  logic [IDX_FIELD_W-1:0]  grid_col,
   input  logic [IDX_FIELD_W-1:0]  grid_row,
   input  logic signed [POS_W-1:0] origin_x,
   input  logic signed [POS_W-1:0] origin_y,
   input  logic [CELL_W-1:0]       cell_size,
   output logic signed [POS_W-1:0] pos_x,
   output logic signed [POS_W-1:0] pos_y
);

   logic [PROD_W-1:0]       prod_x_ff;
   logic [PROD_W-1:0]       prod_y_ff;
   logic signed [POS_W-1:0] pos_x_ff;
   logic signed [POS_W-1:0] pos_y_ff;
   logic signed [POS_W+1:0] sum_x;
   logic signed [POS_W+1:0] sum_y;

   // offset products
   always_ff @(posedge clock) begin
      prod_x_ff <= PROD_W'(grid_clamp(grid_col)) * PROD_W'(cell_size);
      prod_y_ff <= PROD_W'(grid_clamp(grid_row)) * PROD_W'(cell_size);
   end

   // origin plus offset, offset is never negative
   always_comb begin
      sum_x = (POS_W+2)'(origin_x) + $signed({{(POS_W+2-PROD_W){1'b0}}, prod_x_ff});
      sum_y = (POS_W+2)'(origin_y) + $signed({{(POS_W+2-PROD_W){1'b0}}, prod_y_ff});
   end

   // saturate to the signed position range
   always_ff @(posedge clock) begin
      if (sum_x > (POS_W+2)'(32'sh7FFFFFFF)) begin
         pos_x_ff <= 32'sh7FFFFFFF;
      end else begin
         pos_x_ff <= sum_x[POS_W-1:0];
      end
      if (sum_y > (POS_W+2)'(32'sh7FFFFFFF)) begin
         pos_y_ff <= 32'sh7FFFFFFF;
      end else begin
         pos_y_ff <= sum_y[POS_W-1:0];
      end
   end

   assign pos_x = pos_x_ff;
   assign pos_y = pos_y_ff;

endmodule

// File: sv/wpq_checker.sv
// port-level checks for the waypoint heading quaternion block, bound to the top level
module wpq_checker
   import wpq_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // the sequencer is busy right after taking a waypoint
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a transaction");

   // a new result shows up only as the sequencer returns to idle
   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result appeared while busy");

   // no result straight out of reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // pad bit of the result stays clear
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[RSP_DATA_W-1])
      else $error("result pad bit set");

endmodule

bind waypoint_heading_quaternion wpq_checker u_wpq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// File: sim/waypoint_heading_quaternion_tb.sv
// testbench for the waypoint heading quaternion block, with its own bit-exact heading predictor
`timescale 1ns / 1ps
module waypoint_heading_quaternion_tb
   import wpq_pkg::*;
();

   localparam int     DRAIN_CYCLES = 80;
   localparam int     LIMIT_NS     = 10_000_000;
   localparam int     GOAL_DEPTH   = 16;
   localparam longint ANGLE_PI     = 64'sd843314857;
   localparam longint CORDIC_GAIN  = 64'sd652032874;
   localparam longint QUAT_DIAG    = 64'sd23170;
   localparam longint NORM_FLOOR   = 64'sd1099511627776;
   localparam longint POS_MAX      = 64'sd2147483647;
   localparam longint POS_MIN      = -64'sd2147483648;

   // one expected result
   typedef struct {
      logic [POS_W-1:0] goal_x;
      logic [POS_W-1:0] goal_y;
      logic [QZ_W-1:0]  quat_z;
      logic [QW_W-1:0]  quat_w;
   } goal_item_type;

   logic                  clock;
   logic                  reset;
   // grid_col[11:0], grid_row[23:12]
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tvalid;
   logic                  req_tready;
   // goal_x[31:0], goal_y[63:32], quat_z[79:64], quat_w[94:80], zero pad[95]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [POS_W-1:0]      csr_data;

   // predictor copy of registers and previous point
   longint      org_x     = 0;
   longint      org_y     = 0;
   int unsigned cell_sz   = 3277;
   int unsigned dead_band = 33;
   longint      last_x    = 0;
   longint      last_y    = 0;
   bit          have_last = 1'b0;

   // arctangent of 2^-i in q.28
   longint atan_step [24] = '{
      210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
      4193963, 2097109, 1048571, 524287, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048,
      1024, 512, 256, 128, 64, 32
   };

   // expected goals in order, written and read through running counters
   goal_item_type     goal_buf [GOAL_DEPTH];
   int                goal_wr    = 0;
   int                goal_rd    = 0;
   int                fail_cnt   = 0;
   bit                idle_on    = 1'b1;
   int                stall_left = 0;
   logic [IDX_FIELD_W-1:0] last_col = '0;
   logic [IDX_FIELD_W-1:0] last_row = '0;

   waypoint_heading_quaternion u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // grid index to metres, saturated to 32 bits
   function automatic longint grid_to_metres(input longint org, input logic [11:0] idx);
      longint p;
      p = org + longint'({52'd0, idx}) * longint'(cell_sz);
      if (p > POS_MAX) p = POS_MAX;
      if (p < POS_MIN) p = POS_MIN;
      return p;
   endfunction

   // quadrant-corrected atan2 by cordic vectoring, q.28
   function automatic longint heading_angle(input longint dx, input longint dy);
      longint base, ang, mag, nx, ny;
      int     i;
      base = 0;
      ang  = 0;
      if (dx < 0) begin
         base = (dy >= 0) ? ANGLE_PI : -ANGLE_PI;
         dx   = -dx;
         dy   = -dy;
      end
      mag = (dy < 0) ? -dy : dy;
      if (dx > mag) mag = dx;
      // normalize so the shifts keep enough precision
      while (mag < NORM_FLOOR) begin
         mag = mag * 2;
         dx  = dx * 2;
         dy  = dy * 2;
      end
      for (i = 0; i < CORDIC_STEPS; i++) begin
         if (dy >= 0) begin
            nx  = dx + (dy >>> i);
            ny  = dy - (dx >>> i);
            ang = ang + atan_step[i];
         end else begin
            nx  = dx - (dy >>> i);
            ny  = dy + (dx >>> i);
            ang = ang - atan_step[i];
         end
         dx = nx;
         dy = ny;
      end
      return base + ang;
   endfunction

   // q2.30 to q1.15, round half up, then clamp
   function automatic longint round_q15(input longint v, input longint lo, input longint hi);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      return r;
   endfunction

   // sine and cosine of the half angle by cordic rotation
   function automatic void half_angle_quat(input longint ang, output longint zq,
                                           output longint wq);
      longint x, y, nx, ny;
      int     i;
      x = CORDIC_GAIN;
      y = 0;
      for (i = 0; i < CORDIC_STEPS; i++) begin
         if (ang >= 0) begin
            nx  = x - (y >>> i);
            ny  = y + (x >>> i);
            ang = ang - atan_step[i];
         end else begin
            nx  = x + (y >>> i);
            ny  = y - (x >>> i);
            ang = ang + atan_step[i];
         end
         x = nx;
         y = ny;
      end
      zq = round_q15(y, -32768, 32767);
      wq = round_q15(x, 0, 32767);
   endfunction

   // advance the route and queue the goal the new waypoint releases
   function automatic void predict_goal(input logic [11:0] col, input logic [11:0] row);
      longint        px, py, dx, dy, zq, wq;
      goal_item_type g;
      px = grid_to_metres(org_x, col);
      py = grid_to_metres(org_y, row);
      if (have_last) begin
         dx = px - last_x;
         dy = py - last_y;
         if (dx == 0) begin
            // vertical heading, no deadband
            zq = (dy >= 0) ? QUAT_DIAG : -QUAT_DIAG;
            wq = QUAT_DIAG;
         end else begin
            half_angle_quat(heading_angle(dx, dy) >>> 1, zq, wq);
            if (((zq < 0) ? -zq : zq) <= longint'(dead_band)) zq = 0;
            if (wq <= longint'(dead_band)) wq = 0;
         end
         g.goal_x = last_x[31:0];
         g.goal_y = last_y[31:0];
         g.quat_z = zq[15:0];
         g.quat_w = wq[14:0];
         goal_buf[goal_wr % GOAL_DEPTH] = g;
         goal_wr++;
      end
      last_x    = px;
      last_y    = py;
      have_last = 1'b1;
   endfunction

   task automatic check_field(input string name, input logic signed [63:0] want_v,
                              input logic signed [63:0] got_v);
      if (got_v !== want_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
         fail_cnt++;
      end
   endtask

   // result side: random stall bursts
   always @(negedge clock) begin
      if (idle_on && stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each result transaction with the oldest expected goal
   always @(posedge clock) begin
      goal_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (goal_wr == goal_rd) begin
            $error("unexpected result transaction: tdata %h", rsp_tdata);
            fail_cnt++;
         end else begin
            want = goal_buf[goal_rd % GOAL_DEPTH];
            goal_rd++;
            check_field("goal_x", $signed(want.goal_x), $signed(rsp_tdata[31:0]));
            check_field("goal_y", $signed(want.goal_y), $signed(rsp_tdata[63:32]));
            check_field("quat_z", $signed(want.quat_z), $signed(rsp_tdata[79:64]));
            check_field("quat_w", {49'd0, want.quat_w}, {49'd0, rsp_tdata[94:80]});
            check_field("tdata pad", 64'sd0, {63'd0, rsp_tdata[95]});
         end
      end
   end

   // one waypoint transaction, entered and left at a falling edge
   task automatic send_waypoint(input logic [11:0] col, input logic [11:0] row);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tdata  <= {row, col};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_goal(col, row);
      last_col = col;
      last_row = row;
      @(negedge clock);
   endtask

   // drop valid, wait for all goals, then let the sequencer settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (goal_wr != goal_rd) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [POS_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_ORIGIN_X:  org_x = longint'($signed(value));
         CSR_ORIGIN_Y:  org_y = longint'($signed(value));
         CSR_CELL_SIZE: cell_sz = 32'(value[15:0]);
         CSR_ZERO_BAND: dead_band = 32'(value[14:0]);
         default: ;
      endcase
   endtask

   function automatic logic [POS_W-1:0] pick_origin();
      case ($urandom_range(0, 3))
         0:       return 32'($urandom);
         1:       return 32'(int'($urandom_range(0, 13107200)) - 6553600);
         2:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 32'h1000_0000));
         default: return 32'h8000_0000 + 32'($urandom_range(0, 32'h0100_0000));
      endcase
   endfunction

   task automatic shuffle_csr();
      logic [POS_W-1:0] cell_v, band_v;
      case ($urandom_range(0, 9))
         6:       cell_v = 32'd0;
         7:       cell_v = 32'd65535;
         8, 9:    cell_v = 32'($urandom_range(0, 65535));
         default: cell_v = 32'($urandom_range(1, 6554));
      endcase
      case ($urandom_range(0, 9))
         7:       band_v = 32'd0;
         8:       band_v = 32'd32767;
         9:       band_v = 32'($urandom_range(0, 32767));
         default: band_v = 32'($urandom_range(0, 200));
      endcase
      csr_write(CSR_ORIGIN_X, pick_origin());
      csr_write(CSR_ORIGIN_Y, pick_origin());
      csr_write(CSR_CELL_SIZE, cell_v);
      csr_write(CSR_ZERO_BAND, band_v);
   endtask

   // mostly routes that wander, with runs along a row or column and repeats
   task automatic pick_waypoint(output logic [11:0] col, output logic [11:0] row);
      int c, r;
      case ($urandom_range(0, 9))
         4, 5: begin
            c   = int'(last_col) + int'($urandom_range(0, 16)) - 8;
            r   = int'(last_row) + int'($urandom_range(0, 16)) - 8;
            c   = (c < 0) ? 0 : ((c > 4095) ? 4095 : c);
            r   = (r < 0) ? 0 : ((r > 4095) ? 4095 : r);
            col = 12'(c);
            row = 12'(r);
         end
         6: begin
            col = last_col;
            row = 12'($urandom);
         end
         7: begin
            col = 12'($urandom);
            row = last_row;
         end
         8: begin
            col = last_col;
            row = last_row;
         end
         9: begin
            col = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
            row = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
         end
         default: begin
            col = 12'($urandom);
            row = 12'($urandom);
         end
      endcase
   endtask

   task automatic run_route(input int n_points);
      logic [11:0] col, row;
      shuffle_csr();
      repeat (n_points) begin
         pick_waypoint(col, row);
         send_waypoint(col, row);
      end
      wait_idle();
   endtask

   // reset register values: first point, equal points, axes, deadband near 0 and 180
   task automatic test_default_csr();
      send_waypoint(12'd0, 12'd0);
      send_waypoint(12'd0, 12'd0);
      send_waypoint(12'd0, 12'd100);
      send_waypoint(12'd0, 12'd0);
      send_waypoint(12'd4095, 12'd1);
      send_waypoint(12'd0, 12'd0);
      send_waypoint(12'd4095, 12'd0);
      send_waypoint(12'd0, 12'd0);
      send_waypoint(12'd4095, 12'd4095);
      send_waypoint(12'd0, 12'd4095);
      send_waypoint(12'd4095, 12'd0);
      send_waypoint(12'd0, 12'd1);
      send_waypoint(12'd4095, 12'd4095);
      wait_idle();
   endtask

   // register extremes: position saturation, full deadband, zero cell size
   task automatic test_csr_extremes();
      csr_write(CSR_ORIGIN_X, 32'h7F00_0000);
      csr_write(CSR_ORIGIN_Y, 32'h8000_0000);
      csr_write(CSR_CELL_SIZE, 32'd65535);
      csr_write(CSR_ZERO_BAND, 32'd32767);
      send_waypoint(12'd0, 12'd0);
      send_waypoint(12'd4095, 12'd4095);
      send_waypoint(12'd4095, 12'd0);
      send_waypoint(12'd0, 12'd10);
      wait_idle();
      csr_write(CSR_ORIGIN_X, 32'h8000_0000);
      csr_write(CSR_ORIGIN_Y, 32'h7FF0_0000);
      csr_write(CSR_ZERO_BAND, 32'd0);
      send_waypoint(12'd0, 12'd0);
      send_waypoint(12'd4095, 12'd4095);
      send_waypoint(12'd100, 12'd4095);
      send_waypoint(12'd4095, 12'd0);
      wait_idle();
      csr_write(CSR_ORIGIN_X, 32'd0);
      csr_write(CSR_ORIGIN_Y, 32'd0);
      csr_write(CSR_CELL_SIZE, 32'd0);
      csr_write(CSR_ZERO_BAND, 32'd32767);
      send_waypoint(12'd5, 12'd7);
      send_waypoint(12'd4095, 12'd4095);
      wait_idle();
   endtask

   task automatic test_random_routes();
      repeat (6) run_route(150);
   endtask

   // final stretch with both sides always ready
   task automatic test_back_to_back();
      idle_on = 1'b0;
      run_route(50);
   endtask

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tdata  = '0;
      req_tvalid = 1'b0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_csr();
      test_csr_extremes();
      test_random_routes();
      test_back_to_back();
      wait_idle();
      if (fail_cnt == 0) begin
         $display("waypoint_heading_quaternion_tb: PASS");
      end else begin
         $display("waypoint_heading_quaternion_tb: FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(LIMIT_NS);
      $display("waypoint_heading_quaternion_tb: FAIL");
      $finish;
   end

endmodule
